[hdl/csr_spmv_pkg.sv]
package csr_spmv_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;

  typedef enum logic [1:0] {
    MODE_VEC_WRITE = 2'd0,
    MODE_NONZERO   = 2'd1,
    MODE_EMPTY_ROW = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_ROW_COUNT = 1'b0;

  // Travels alongside an item through the arithmetic pipeline.
  typedef struct packed {
    logic vld;
    logic nonzero;
    logic last;
  } tag_t;

  // Column modulo the store depth. The depth is a power of two, so the wrap
  // keeps only the low address bits.
  function automatic logic [ADDR_W-1:0] col_to_addr(input logic [9:0] col);
    logic [31:0] c;
    c = 32'(col);
    return ADDR_W'(c % VECTOR_DEPTH);
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // IEEE single addition, round to nearest even, subnormals kept.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y;
    logic        sx, sy;
    logic [7:0]  ex, ey;
    logic [23:0] mx, my;
    logic [7:0]  d;
    logic [26:0] yx, ys;
    logic        stk;
    logic [27:0] r;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [8:0]  sh;
    logic [26:0] n;
    logic        g, st, inc;
    logic [7:0]  ef;
    logic [30:0] res;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      return CANON_NAN;
    end
    if (a_inf) begin
      return a;
    end
    if (b_inf) begin
      return b;
    end
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    sx = x[31];
    sy = y[31];
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {(x[30:23] != 8'd0), x[22:0]};
    my = {(y[30:23] != 8'd0), y[22:0]};
    d = ex - ey;
    yx = {my, 3'b000};
    if (d >= 8'd27) begin
      ys = 27'd0;
      stk = |my;
    end else begin
      ys = yx >> d;
      stk = |(yx & ~(27'h7FFFFFF << d));
    end
    ys[0] = ys[0] | stk;
    if (sx == sy) begin
      r = {1'b0, mx, 3'b000} + {1'b0, ys};
    end else begin
      r = {1'b0, mx, 3'b000} - {1'b0, ys};
    end
    if (r == 28'd0) begin
      return {sx & sy, 31'd0};
    end
    e = {1'b0, ex};
    if (r[27]) begin
      n = r[27:1];
      n[0] = n[0] | r[0];
      e = e + 9'd1;
    end else begin
      lz = lzc27(r[26:0]);
      sh = (9'(lz) < (e - 9'd1)) ? 9'(lz) : (e - 9'd1);
      n = r[26:0] << sh;
      e = e - sh;
    end
    if (e >= 9'd255) begin
      return {sx, 8'hFF, 23'd0};
    end
    g = n[2];
    st = n[1] | n[0];
    inc = g & (st | n[3]);
    ef = n[26] ? e[7:0] : 8'd0;
    res = {ef, n[25:3]} + 31'(inc);
    return {sx, res};
  endfunction

endpackage

[hdl/csr_spmv_vec_store.sv]
module csr_spmv_vec_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [csr_spmv_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [31:0]                      wr_data,
  input  logic                             rd_en,
  input  logic [csr_spmv_pkg::ADDR_W-1:0]  rd_addr,
  output logic [31:0]                      rd_data
);

  logic [31:0] mem [csr_spmv_pkg::VECTOR_DEPTH];
  logic [31:0] rd_data_r;

  // At most one transfer per cycle; its read of the entry it writes gets
  // the old data, and a read in the cycle after a write sees it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/csr_spmv_fmul.sv]
module csr_spmv_fmul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  csr_spmv_pkg::tag_t  tag_in,
  output logic [31:0]         prod,
  output csr_spmv_pkg::tag_t  tag_out
);

  // First stage: unpack and form the 48-bit significand product.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [10:0] ea_eff, eb_eff;

  always_comb begin
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ma     = {(a[30:23] != 8'd0), a[22:0]};
    mb     = {(b[30:23] != 8'd0), b[22:0]};
    ea_eff = (a[30:23] == 8'd0) ? 11'd1 : {3'b000, a[30:23]};
    eb_eff = (b[30:23] == 8'd0) ? 11'd1 : {3'b000, b[30:23]};
  end

  logic [47:0]        p_r;
  logic signed [10:0] exp_r;
  logic               sign_r, nan_r, inf_r, zero_r;
  csr_spmv_pkg::tag_t tag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (en) begin
      tag1_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= ma * mb;
      exp_r  <= $signed(ea_eff + eb_eff - 11'd127);
      sign_r <= a[31] ^ b[31];
      nan_r  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf_r  <= a_inf | b_inf;
      zero_r <= a_zero | b_zero;
    end
  end

  // Second stage: normalize, denormalize into the subnormal range, round.
  logic [5:0]         lz;
  logic signed [10:0] en_exp;
  logic [47:0]        shl, s2;
  logic [10:0]        rs;
  logic               stk, g, st, inc;
  logic [7:0]         ef;
  logic [30:0]        mag;
  logic [31:0]        prod_nxt;

  always_comb begin
    lz     = csr_spmv_pkg::lzc48(p_r);
    en_exp = exp_r + 11'sd1 - $signed({5'b00000, lz});
    shl    = p_r << lz;
    rs     = 11'd0;
    s2     = shl;
    stk    = 1'b0;
    if (en_exp <= 11'sd0) begin
      rs = 11'(11'sd1 - en_exp);
      if (rs >= 11'd48) begin
        s2  = 48'd0;
        stk = |p_r;
      end else begin
        s2  = shl >> rs;
        stk = |(shl & ~(48'hFFFF_FFFF_FFFF << rs));
      end
    end
    g   = s2[23];
    st  = (|s2[22:0]) | stk;
    inc = g & (st | s2[24]);
    ef  = (en_exp <= 11'sd0) ? 8'd0 : en_exp[7:0];
    mag = {ef, s2[46:24]} + 31'(inc);
    if (nan_r) begin
      prod_nxt = csr_spmv_pkg::CANON_NAN;
    end else if (inf_r || (en_exp >= 11'sd255)) begin
      prod_nxt = {sign_r, 8'hFF, 23'd0};
    end else if (zero_r) begin
      prod_nxt = {sign_r, 31'd0};
    end else begin
      prod_nxt = {sign_r, mag};
    end
  end

  logic [31:0]        prod_r;
  csr_spmv_pkg::tag_t tag2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod    = prod_r;
  assign tag_out = tag2_r;

endmodule

[hdl/csr_spmv_facc.sv]
module csr_spmv_facc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [31:0]         prod,
  input  csr_spmv_pkg::tag_t  tag,
  input  logic [15:0]         row_count,
  output logic                out_valid,
  output logic [31:0]         out_sum,
  output logic [15:0]         out_row
);

  logic [31:0] acc_r;
  logic [15:0] row_r;
  logic        out_valid_r;
  logic [31:0] out_sum_r;
  logic [15:0] out_row_r;

  logic [31:0] sum;
  logic [16:0] limit;
  logic [16:0] row_inc;
  logic [15:0] row_next;
  logic        emit;

  always_comb begin
    sum      = csr_spmv_pkg::fp_add(acc_r, prod);
    limit    = (row_count == 16'd0) ? 17'h10000 : {1'b0, row_count};
    row_inc  = {1'b0, row_r} + 17'd1;
    row_next = (row_inc >= limit) ? 16'd0 : row_inc[15:0];
    emit     = tag.vld && (!tag.nonzero || tag.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 32'd0;
      row_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= emit;
      if (tag.vld) begin
        if (emit) begin
          acc_r <= 32'd0;
          row_r <= row_next;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit) begin
      out_sum_r <= tag.nonzero ? sum : 32'd0;
      out_row_r <= row_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;
  assign out_row   = out_row_r;

endmodule

[hdl/csr_sparse_matrix_vector_multiply_core.sv]
// CSR sparse matrix times dense vector in IEEE single precision. Load x
// first with vector-write transfers, then stream the nonzeros of each row;
// the nonzero marked with tlast (or an empty-row transfer) yields the row
// sum and its row number. The core takes one transfer every cycle while
// the result side is ready. The four registers between the edge that takes
// the last nonzero of a row and the presentation of its result are the
// vector store read, the two multiplier stages and the accumulate stage,
// and the first of them loads at that edge. The running sum is a
// combinational floating-point add into a register that closes on itself,
// so consecutive nonzeros of a row never wait on each other. A stalled
// result holds the whole pipeline.
module csr_sparse_matrix_vector_multiply_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // column[9:0], value_bits[41:10], zero fill
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // row_sum_bits[31:0], row_number[47:32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        en;
  logic        in_xfer;
  logic [1:0]  mode;
  logic [9:0]  column;
  logic [31:0] value_bits;
  logic [csr_spmv_pkg::ADDR_W-1:0] addr;

  assign en         = out_tready | ~out_tvalid;
  assign in_tready  = en;
  assign in_xfer    = in_tvalid & in_tready;
  assign mode       = in_tuser;
  assign column     = in_tdata[9:0];
  assign value_bits = in_tdata[41:10];
  assign addr       = csr_spmv_pkg::col_to_addr(column);

  // Configuration register.
  logic [15:0] row_count_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == csr_spmv_pkg::REG_ROW_COUNT)) begin
      row_count_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == csr_spmv_pkg::REG_ROW_COUNT) ?
                      {16'd0, row_count_r} : 32'd0;

  // Vector store and the stage that lines up with its read data.
  logic [31:0] x_data;

  csr_spmv_vec_store u_store (
    .clk     (clk),
    .wr_en   (in_xfer && (mode == csr_spmv_pkg::MODE_VEC_WRITE)),
    .wr_addr (addr),
    .wr_data (value_bits),
    .rd_en   (en),
    .rd_addr (addr),
    .rd_data (x_data)
  );

  logic [31:0]        val1_r;
  csr_spmv_pkg::tag_t tag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (en) begin
      tag1_r.vld     <= in_xfer && ((mode == csr_spmv_pkg::MODE_NONZERO) ||
                                    (mode == csr_spmv_pkg::MODE_EMPTY_ROW));
      tag1_r.nonzero <= (mode == csr_spmv_pkg::MODE_NONZERO);
      tag1_r.last    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1_r <= value_bits;
    end
  end

  logic [31:0]        prod;
  csr_spmv_pkg::tag_t prod_tag;

  csr_spmv_fmul u_fmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .a       (val1_r),
    .b       (x_data),
    .tag_in  (tag1_r),
    .prod    (prod),
    .tag_out (prod_tag)
  );

  logic [31:0] row_sum;
  logic [15:0] row_number;

  csr_spmv_facc u_facc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .prod      (prod),
    .tag       (prod_tag),
    .row_count (row_count_r),
    .out_valid (out_tvalid),
    .out_sum   (row_sum),
    .out_row   (row_number)
  );

  assign out_tdata = {row_number, row_sum};

endmodule

[tb/csr_sparse_matrix_vector_multiply_core_tb.sv]
module csr_sparse_matrix_vector_multiply_core_tb;

  typedef struct {
    bit [31:0] sum;
    bit [15:0] row;
  } row_result_t;

  class row_sum_scoreboard;
    bit [31:0]   vec [1024];
    bit [31:0]   acc;
    bit [15:0]   row;
    bit [15:0]   rows;
    row_result_t pending_rows[$];
    int          errors;

    function new();
      acc = 0;
      row = 0;
      rows = 16'd1;
      errors = 0;
      foreach (vec[i]) vec[i] = 0;
    endfunction

    // Rounds sign * m * 2^e to single precision, nearest even.
    function bit [31:0] round_pack(bit s, bit [127:0] m, int e);
      int         p;
      int         sh;
      int         e2;
      int         b;
      bit [127:0] kept;
      bit [127:0] rem;
      bit [127:0] half;
      p = 0;
      if (m == 0) return {s, 31'd0};
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      sh = p - 23;
      if (sh < -149 - e) sh = -149 - e;
      if (sh > 100) return {s, 31'd0};
      if (sh > 0) begin
        kept = m >> sh;
        rem = m & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      end else begin
        kept = m << (-sh);
      end
      e2 = e + sh;
      if (kept[24]) begin
        kept = kept >> 1;
        e2 = e2 + 1;
      end
      if (kept[23]) begin
        b = e2 + 150;
        if (b >= 255) return {s, 8'hFF, 23'd0};
        return {s, b[7:0], kept[22:0]};
      end
      return {s, 8'd0, kept[22:0]};
    endfunction

    function bit is_nan(bit [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function bit is_inf(bit [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 0);
    endfunction

    function bit [23:0] sig_of(bit [31:0] a);
      return (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    endfunction

    function int exp_of(bit [31:0] a);
      return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function bit [31:0] f_mul(bit [31:0] a, bit [31:0] b);
      bit s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return csr_spmv_pkg::CANON_NAN;
      if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
        return csr_spmv_pkg::CANON_NAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      return round_pack(s, 128'(sig_of(a)) * 128'(sig_of(b)), exp_of(a) + exp_of(b));
    endfunction

    function bit [31:0] f_add(bit [31:0] a, bit [31:0] b);
      bit [31:0]  hi, lo;
      bit [127:0] big, sml, m;
      int         d;
      int         e;
      bit         s;
      if (is_nan(a) || is_nan(b)) return csr_spmv_pkg::CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return csr_spmv_pkg::CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (exp_of(a) >= exp_of(b)) begin
        hi = a;
        lo = b;
      end else begin
        hi = b;
        lo = a;
      end
      d = exp_of(hi) - exp_of(lo);
      // Far below the rounding point the smaller operand only acts as a sticky bit.
      if (d > 50) begin
        big = 128'(sig_of(hi)) << 50;
        sml = (sig_of(lo) != 0) ? 128'd1 : 128'd0;
        e = exp_of(hi) - 50;
      end else begin
        big = 128'(sig_of(hi)) << d;
        sml = 128'(sig_of(lo));
        e = exp_of(lo);
      end
      if (hi[31] == lo[31]) begin
        m = big + sml;
        s = hi[31];
      end else if (big >= sml) begin
        m = big - sml;
        s = hi[31];
      end else begin
        m = sml - big;
        s = lo[31];
      end
      if (m == 0) return {a[31] & b[31], 31'd0};
      return round_pack(s, m, e);
    endfunction

    function void finish_row(bit [31:0] sum);
      row_result_t r;
      int          lim;
      int          nxt;
      r.sum = is_nan(sum) ? csr_spmv_pkg::CANON_NAN : sum;
      r.row = row;
      pending_rows.push_back(r);
      lim = (rows == 0) ? 65536 : int'(rows);
      nxt = int'(row) + 1;
      row = (nxt >= lim) ? 16'd0 : 16'(nxt);
      acc = 0;
    endfunction

    function void note_input(csr_spmv_pkg::mode_t mode, bit [9:0] col, bit [31:0] val,
                             bit last);
      case (mode)
        csr_spmv_pkg::MODE_VEC_WRITE: vec[col] = val;
        csr_spmv_pkg::MODE_NONZERO: begin
          acc = f_add(acc, f_mul(val, vec[col]));
          if (last) finish_row(acc);
        end
        csr_spmv_pkg::MODE_EMPTY_ROW: finish_row(32'd0);
        default: ;
      endcase
    endfunction

    function void check_result(bit [31:0] sum, bit [15:0] r);
      row_result_t x;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row result sum=%h row=%0d", $time, sum, r);
        errors++;
        return;
      end
      x = pending_rows.pop_front();
      if (x.sum !== sum) begin
        $display("%0t: row sum mismatch: expected %h, got %h", $time, x.sum, sum);
        errors++;
      end
      if (x.row !== r) begin
        $display("%0t: row number mismatch: expected %0d, got %0d", $time, x.row, r);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // column[9:0], value_bits[41:10], zero fill
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // row_sum_bits[31:0], row_number[47:32]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  row_sum_scoreboard sb;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  cycles;
  int  written_cols[$];
  bit  col_written [1024];

  csr_sparse_matrix_vector_multiply_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** csr_sparse_matrix_vector_multiply_core: FAILED **");
      $finish;
    end
  end

  // Inputs change only at rising edges, so the falling edge sees the values
  // that the next rising edge will act on.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(csr_spmv_pkg::mode_t'(in_tuser), in_tdata[9:0], in_tdata[41:10],
                      in_tlast);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[31:0], out_tdata[47:32]);
    end
  end

  task automatic send(csr_spmv_pkg::mode_t mode, bit [9:0] col, bit [31:0] val, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'd0, val, col};
    in_tlast <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    if (mode == csr_spmv_pkg::MODE_VEC_WRITE && !col_written[col]) begin
      col_written[col] = 1'b1;
      written_cols.push_back(col);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_row_count(bit [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * csr_spmv_pkg::REG_ROW_COUNT);
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.rows = value;
  endtask

  function automatic bit [31:0] rand_float();
    bit [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v[30:23] = 8'($urandom_range(154, 100));
      6: ;
      7: v[30:23] = 8'd0;
      8: v[30:0] = 31'd0;
      default: v[30:23] = 8'hFF;
    endcase
    return v;
  endfunction

  task automatic random_items(int count, bit pause_midway);
    int n;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pause_midway && n == count / 2) begin
        in_tvalid <= 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge clk);
      end
      if (pick < 22) begin
        send(csr_spmv_pkg::MODE_VEC_WRITE, 10'($urandom), rand_float(), 1'($urandom));
      end else if (pick < 88) begin
        send(csr_spmv_pkg::MODE_NONZERO,
             10'(written_cols[$urandom_range(written_cols.size() - 1)]),
             rand_float(), $urandom_range(3) == 0);
      end else if (pick < 96) begin
        send(csr_spmv_pkg::MODE_EMPTY_ROW, 10'($urandom), $urandom, 1'($urandom));
      end else begin
        send(csr_spmv_pkg::MODE_UNUSED, 10'($urandom), $urandom, 1'($urandom));
        n--;
      end
      n++;
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tx_idle_pct = 26;
    rx_idle_pct = 68;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Store corners, then products that hit the special floating-point cases.
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd0, 32'h3F800000, 1'b0);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd1023, 32'hC0000000, 1'b1);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd512, 32'h00000001, 1'b0);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd5, 32'h7F800000, 1'b0);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd6, 32'hFFFFFFFF, 1'b0);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd7, 32'h7F7FFFFF, 1'b0);
    send(csr_spmv_pkg::MODE_VEC_WRITE, 10'd8, 32'h80000000, 1'b0);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd0, 32'h3F800000, 1'b0);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd1023, 32'h40400000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd0, 32'h40490FDB, 1'b0);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd0, 32'hC0490FDB, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd5, 32'h00000000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd7, 32'h7F7FFFFF, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd512, 32'h00000001, 1'b0);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd512, 32'h3F000000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd6, 32'h00000000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd8, 32'h80000000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd1023, 32'h12345678, 1'b0);
    send(csr_spmv_pkg::MODE_EMPTY_ROW, 10'd3, 32'hFFFFFFFF, 1'b1);
    send(csr_spmv_pkg::MODE_UNUSED, 10'd0, 32'h3F800000, 1'b1);
    send(csr_spmv_pkg::MODE_NONZERO, 10'd5, 32'hBF800000, 1'b1);
    drain();

    write_row_count(16'd3);
    random_items(550, 1'b1);
    drain();

    tx_idle_pct = 68;
    rx_idle_pct = 26;
    write_row_count(16'd65535);
    random_items(500, 1'b0);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_row_count(16'd0);
    random_items(300, 1'b0);
    drain();
    write_row_count(16'd2);
    random_items(300, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("** csr_sparse_matrix_vector_multiply_core: PASSED **");
    end else begin
      $display("** csr_sparse_matrix_vector_multiply_core: FAILED **");
    end
    $finish;
  end

endmodule
